FILE: design/orfd_pkg.sv
// ----------------------------------------------------------------------------
// orfd_pkg
// Shared types and constants of the overwrite ring FIFO packet drain unit.
// ----------------------------------------------------------------------------
package orfd_pkg;

	localparam int DEPTH_LOG_DEF  = 9;
	localparam int MAX_PACKET_DEF = 64;

	localparam int BYTE_W      = 8;
	localparam int PKT_LEN_W   = 7;
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_DRAIN = 2'd1,
		CMD_SET   = 2'd2
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    out_byte;
		logic [PKT_LEN_W-1:0] packet_length;
		logic                 byte_valid;
		logic                 last_of_packet;
	} out_item_t;

endpackage

FILE: design/orfd_ram.sv
// ----------------------------------------------------------------------------
// orfd_ram
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module orfd_ram
	import orfd_pkg::*;
#(
	parameter int ADDR_W = DEPTH_LOG_DEF
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/orfd_obuf.sv
// ----------------------------------------------------------------------------
// orfd_obuf
// Two-entry output buffer; parts the drain sequencer from the result stream.
// ----------------------------------------------------------------------------
module orfd_obuf
	import orfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	input  logic      pop_ready,
	output logic      out_valid,
	output out_item_t out_item,
	output logic [1:0] count
);

	out_item_t entry_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] count_q;
	logic      pop;

	assign out_valid = (count_q != 2'd0);
	assign out_item  = entry_q[rd_ptr_q];
	assign count     = count_q;
	assign pop       = out_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: design/overwrite_ring_fifo_packet_drain_unit.sv
// ----------------------------------------------------------------------------
// overwrite_ring_fifo_packet_drain_unit
// Byte ring FIFO that overwrites the oldest byte when full and drains
// packets of up to MAX_PACKET bytes on request.
// ----------------------------------------------------------------------------
// Push and set items: taken one per cycle while idle, done in the cycle of
// acceptance. Drain item: one byte read per cycle over the single read port
// of the store while the output buffer has room, each byte registered before
// it enters the buffer; no item is taken until the drain's last read issues.
// Reset clears pointers, active flag, sequencer and output buffer at once;
// the byte store is not cleared.
module overwrite_ring_fifo_packet_drain_unit
	import orfd_pkg::*;
#(
	parameter int DEPTH_LOG  = DEPTH_LOG_DEF,
	parameter int MAX_PACKET = MAX_PACKET_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // data_byte[7:0], enable_flag[8]
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // command[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // out_byte[7:0], packet_length[14:8]
	output logic                   m_tuser,   // byte_valid
	output logic                   m_tlast    // last_of_packet
);

	localparam int ADDR_W = DEPTH_LOG;
	localparam int LEN_W  = $clog2(MAX_PACKET + 1);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] wp_q, rp_q, raddr_q, wp_nxt, diff;
	logic              active_q;
	logic [LEN_W-1:0]  rem_q, len_q, len_calc;
	logic              vld_s1, last_s1, data_s1;
	logic              acc, issue, credit, pop, ram_we;
	cmd_t              cmd;
	logic [BYTE_W-1:0] ram_rdata;
	logic [1:0]        ob_count;
	out_item_t         ob_in, ob_out;

	assign acc      = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign wp_nxt   = wp_q + 1'b1;
	assign diff     = wp_q - rp_q;
	assign len_calc = (32'(diff) > MAX_PACKET) ? LEN_W'(MAX_PACKET) : LEN_W'(diff);
	assign pop      = m_tvalid && m_tready;
	assign credit   = (3'(ob_count) + 3'(vld_s1)) < (3'd2 + 3'(pop));
	assign issue    = (state_q == ST_DRAIN) && credit;
	assign ram_we   = acc && (cmd == CMD_PUSH) && active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && cmd == CMD_DRAIN) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (issue && rem_q <= LEN_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			active_q <= 1'b0;
		end else if (acc) begin
			unique case (cmd)
				CMD_PUSH: begin
					if (active_q) begin
						wp_q <= wp_nxt;
						if (wp_nxt == rp_q) begin
							rp_q <= rp_q + 1'b1;
						end
					end
				end
				CMD_DRAIN: begin
					if (len_calc[1:0] != 2'd0) begin
						wp_q <= '0;
						rp_q <= '0;
					end else begin
						rp_q <= rp_q + ADDR_W'(len_calc);
					end
				end
				CMD_SET: begin
					active_q <= s_tdata[BYTE_W];
					if (!s_tdata[BYTE_W]) begin
						wp_q <= '0;
						rp_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (acc && cmd == CMD_DRAIN) begin
				rem_q <= len_calc;
			end else if (issue && rem_q != '0) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_DRAIN) begin
			raddr_q <= rp_q;
			len_q   <= len_calc;
		end else if (issue) begin
			raddr_q <= raddr_q + 1'b1;
		end
		if (issue) begin
			last_s1 <= (rem_q <= LEN_W'(1));
			data_s1 <= (rem_q != '0);
		end
	end

	orfd_ram #(
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(s_tdata[BYTE_W-1:0]),
		.re   (issue),
		.raddr(raddr_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		ob_in.out_byte       = data_s1 ? ram_rdata : '0;
		ob_in.packet_length  = data_s1 ? PKT_LEN_W'(len_q) : '0;
		ob_in.byte_valid     = data_s1;
		ob_in.last_of_packet = last_s1;
	end

	orfd_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (vld_s1),
		.push_item(ob_in),
		.pop_ready(m_tready),
		.out_valid(m_tvalid),
		.out_item (ob_out),
		.count    (ob_count)
	);

	assign m_tdata = {1'b0, ob_out.packet_length, ob_out.out_byte};
	assign m_tuser = ob_out.byte_valid;
	assign m_tlast = ob_out.last_of_packet;

endmodule

FILE: design/orfd_checker.sv
// ----------------------------------------------------------------------------
// orfd_checker
// Port-level checks of the overwrite ring FIFO packet drain unit.
// ----------------------------------------------------------------------------
module orfd_checker
	import orfd_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic [IN_TUSER_W-1:0]  s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata == 16'd0)
		else $error("empty packet result malformed");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[14:8] != 7'd0 && m_tdata[14:8] <= 7'd64)
		else $error("data result with bad packet length");

	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_DRAIN |=> !s_tready)
		else $error("item taken right after a drain");

endmodule

bind overwrite_ring_fifo_packet_drain_unit orfd_checker u_orfd_checker (.*);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the overwrite ring FIFO packet drain unit. A local
// copy of the byte ring predicts every drained packet; the checker matches
// each output item against the oldest prediction. Directed items cover the
// inactive FIFO, empty drains, pointer reset on short drains, deactivation
// and the unused command. A long fill covers the packet length limit and
// packets drained back to back. Random push bursts and drains follow, with
// idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import orfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RING_SLOTS  = 1 << DEPTH_LOG_DEF;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;
	localparam int          SETTLE_CYC  = 8;
	localparam int          WD_LIMIT    = 2000;
	localparam int          RAND_ITEMS  = 180;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // data_byte[7:0], enable_flag[8]
	logic [IN_TUSER_W-1:0]  s_tuser  = '0;   // command[1:0]
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // out_byte[7:0], packet_length[14:8]
	logic                   m_tuser;         // byte_valid
	logic                   m_tlast;         // last_of_packet

	logic [BYTE_W-1:0]        ring_mem [RING_SLOTS];
	logic [DEPTH_LOG_DEF-1:0] ring_wr;
	logic [DEPTH_LOG_DEF-1:0] ring_rd;
	logic                     ring_active;
	out_item_t                drained_q [$];

	int  errors    = 0;
	int  gap_odds  = 4;
	bit  no_idle   = 1'b0;
	int  stall_left = 0;
	int  quiet_cyc  = 0;

	overwrite_ring_fifo_packet_drain_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic predict_item(input logic [1:0] cmd, input logic [7:0] data, input logic en);
		logic [DEPTH_LOG_DEF-1:0] nxt;
		int unsigned              len;
		out_item_t                res;
		case (cmd)
			CMD_PUSH: begin
				if (ring_active) begin
					nxt = ring_wr + 1'b1;
					if (nxt == ring_rd)
						ring_rd = ring_rd + 1'b1;
					ring_mem[ring_wr] = data;
					ring_wr = nxt;
				end
			end
			CMD_DRAIN: begin
				len = int'(DEPTH_LOG_DEF'(ring_wr - ring_rd));
				if (len > MAX_PACKET_DEF)
					len = MAX_PACKET_DEF;
				if (len == 0) begin
					res = '{out_byte: '0, packet_length: '0, byte_valid: 1'b0,
						last_of_packet: 1'b1};
					drained_q.push_back(res);
				end else begin
					for (int k = 0; k < len; k++) begin
						res.out_byte       = ring_mem[DEPTH_LOG_DEF'(ring_rd + k)];
						res.packet_length  = PKT_LEN_W'(len);
						res.byte_valid     = 1'b1;
						res.last_of_packet = (k + 1 == len);
						drained_q.push_back(res);
					end
					ring_rd = ring_rd + DEPTH_LOG_DEF'(len);
					if (len % 4 != 0) begin
						ring_wr = '0;
						ring_rd = '0;
					end
				end
			end
			CMD_SET: begin
				ring_active = en;
				if (!en) begin
					ring_wr = '0;
					ring_rd = '0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [1:0] cmd, input logic [7:0] data, input logic en);
		if (!no_idle && gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, en, data};
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(cmd, data, en);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (drained_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic push_random(input int n);
		repeat (n) send_item(CMD_PUSH, 8'($urandom), 1'($urandom));
	endtask

	task automatic test_inactive_fifo();
		send_item(CMD_DRAIN, 8'h00, 1'b0);
		send_item(CMD_PUSH, 8'h3C, 1'b1);
		send_item(CMD_UNUSED, 8'hFF, 1'b1);
		send_item(CMD_DRAIN, 8'hFF, 1'b1);
	endtask

	task automatic test_push_drain();
		send_item(CMD_SET, 8'h00, 1'b1);
		send_item(CMD_PUSH, 8'h00, 1'b0);
		send_item(CMD_PUSH, 8'hFF, 1'b1);
		send_item(CMD_PUSH, 8'hA5, 1'b0);
		send_item(CMD_PUSH, 8'h5A, 1'b1);
		send_item(CMD_DRAIN, 8'h00, 1'b0);
		send_item(CMD_PUSH, 8'h81, 1'b0);
		send_item(CMD_PUSH, 8'h7E, 1'b1);
		send_item(CMD_PUSH, 8'hC3, 1'b0);
		send_item(CMD_DRAIN, 8'hFF, 1'b1);
		send_item(CMD_DRAIN, 8'h00, 1'b0);
		send_item(CMD_PUSH, 8'h11, 1'b1);
		send_item(CMD_SET, 8'hFF, 1'b0);
		send_item(CMD_DRAIN, 8'h00, 1'b1);
		send_item(CMD_UNUSED, 8'h00, 1'b0);
		send_item(CMD_SET, 8'hFF, 1'b1);
	endtask

	task automatic test_long_fill();
		push_random($urandom_range(MAX_PACKET_DEF + 4, MAX_PACKET_DEF + 24));
		wait_drained();
		repeat (3) send_item(CMD_DRAIN, 8'($urandom), 1'($urandom));
	endtask

	task automatic test_random_traffic();
		int  sent;
		int  n;
		int  pick;
		int  extra;
		bit  paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < RAND_ITEMS) begin
			if (sent > RAND_ITEMS * 4 / 5)
				no_idle = 1'b1;
			else
				gap_odds = $urandom_range(0, 3) * 3;
			if (!paused && sent > RAND_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				n = $urandom_range(1, 16);
				if ($urandom_range(0, 4) == 0)
					n = $urandom_range(60, 80);
				push_random(n);
				send_item(CMD_DRAIN, 8'($urandom), 1'($urandom));
				sent += n + 1;
			end else if (pick < 16) begin
				extra = $urandom_range(0, 3);
				send_item(CMD_SET, 8'($urandom), 1'b0);
				push_random(extra);
				send_item(CMD_DRAIN, 8'($urandom), 1'($urandom));
				send_item(CMD_SET, 8'($urandom), 1'b1);
				sent += extra + 3;
			end else if (pick < 18) begin
				send_item(CMD_UNUSED, 8'($urandom), 1'($urandom));
				sent += 1;
			end else begin
				send_item(CMD_DRAIN, 8'($urandom), 1'($urandom));
				sent += 1;
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{out_byte: m_tdata[7:0], packet_length: m_tdata[14:8],
				byte_valid: m_tuser, last_of_packet: m_tlast};
			if (drained_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: expected none, actual byte %h len %0d valid %b last %b",
					$time, got.out_byte, got.packet_length, got.byte_valid,
					got.last_of_packet);
			end else begin
				want = drained_q.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: mismatch: expected byte %h len %0d valid %b last %b, actual byte %h len %0d valid %b last %b",
						$time, want.out_byte, want.packet_length, want.byte_valid,
						want.last_of_packet, got.out_byte, got.packet_length,
						got.byte_valid, got.last_of_packet);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= WD_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		ring_wr     = '0;
		ring_rd     = '0;
		ring_active = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_inactive_fifo();
		test_push_drain();
		test_long_fill();
		test_random_traffic();
		wait_drained();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
